FILE: src/xor_mex_occupancy_tree_top_assert.svh
// Assertion macros used by the port checker of the occupancy tree block.
`ifndef XOR_MEX_OCCUPANCY_TREE_TOP_ASSERT_SVH
`define XOR_MEX_OCCUPANCY_TREE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define XMOT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("occupancy tree check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define XMOT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("occupancy tree check failed");

`endif

FILE: src/xmot_pkg.sv
// Package with the beat types, codes and controller types of the occupancy tree block.
package xmot_pkg;

    localparam int VALUE_BITS_DEFAULT = 12;
    localparam int FIELD_W = 12;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic func;
        logic [FIELD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] answer;
        logic was_new;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LEAF_RD,
        S_LEAF_EV,
        S_UP_RD,
        S_UP_EV,
        S_Q_RD,
        S_Q_EV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic rd_leaf;
        logic ins_leaf;
        logic rd_sib;
        logic climb;
        logic rd_pref;
        logic q_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic rd_full;
        logic node_at_top;
        logic lvl_zero;
        logic out_free;
    } t_stat;

endpackage

FILE: src/xor_mex_occupancy_tree_top.sv
// Top level of the XOR mex occupancy tree: a set of values with insert and mex queries.
// The input channel takes one beat per item: func selects insert or query, and
// value holds the value to insert or the XOR mask of the query. The output
// channel returns one beat per item: answer is the smallest value absent from
// the set XOR mask (zero for inserts), and was_new flags an insert that added
// a new value (zero for queries). Both channels use valid and stall.
// Items are handled one at a time. A query walks every tree level from the root
// down to the leaves; an insert stops after the leaf read for a duplicate and
// otherwise sets the leaf and lets the full flags climb towards the root. Each
// tree level takes a read state of the full-flag memory and an evaluate state.
// The next item is accepted in the idle state that follows the load of the
// output register, so a new item is only taken once the last one is through.
// After reset the block clears all 2^(VALUE_BITS + 1) entries of its flag memory
// (8192 at the default width) and holds input stall high until that is done.
// A finished result sits in the output register while the next item is
// accepted; if the receiver still stalls when that item finishes, the block
// waits and keeps input stall high.
module xor_mex_occupancy_tree_top #(
    parameter int VALUE_BITS = xmot_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  xmot_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output xmot_pkg::t_out_item  o_out_item
);
    import xmot_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    xmot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_item.func),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    xmot_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: src/xmot_ctrl.sv
// Controller state machine that sequences clearing, inserts and queries.
module xmot_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_func,
    input  xmot_pkg::t_stat i_stat,
    output xmot_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);
    import xmot_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_in_func == FUNC_QUERY) ? S_Q_RD : S_LEAF_RD;
                end
            end
            S_LEAF_RD: begin
                o_cmd.rd_leaf = 1'b1;
                n_state = S_LEAF_EV;
            end
            S_LEAF_EV: begin
                if (i_stat.rd_full) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.ins_leaf = 1'b1;
                    n_state = S_UP_RD;
                end
            end
            S_UP_RD: begin
                o_cmd.rd_sib = 1'b1;
                n_state = S_UP_EV;
            end
            S_UP_EV: begin
                if (i_stat.rd_full) begin
                    o_cmd.climb = 1'b1;
                    n_state = i_stat.node_at_top ? S_DONE : S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_Q_RD: begin
                o_cmd.rd_pref = 1'b1;
                n_state = S_Q_EV;
            end
            S_Q_EV: begin
                o_cmd.q_step = 1'b1;
                n_state = i_stat.lvl_zero ? S_DONE : S_Q_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: src/xmot_datapath.sv
// Datapath with the full-flag memory, walk registers and the output register.
module xmot_datapath #(
    parameter int VALUE_BITS = xmot_pkg::VALUE_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xmot_pkg::t_cmd     i_cmd,
    input  xmot_pkg::t_in_item i_in_item,
    output xmot_pkg::t_stat    o_stat,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output xmot_pkg::t_out_item o_out_item
);
    import xmot_pkg::*;

    localparam int NW = VALUE_BITS + 1;
    localparam int DEPTH = 1 << NW;
    localparam int LW = $clog2(VALUE_BITS);
    localparam int XW = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;

    logic mem [0:DEPTH-1];
    logic r_rdata;

    logic [NW-1:0] r_clr_addr;
    logic [VALUE_BITS-1:0] r_value;
    logic [NW-1:0] r_node;
    logic [LW-1:0] r_lvl;
    logic [VALUE_BITS-1:0] r_res;
    logic r_was_new;
    logic r_out_valid;
    t_out_item r_out;

    logic [XW-1:0] val_ext;
    logic [XW-1:0] res_ext;
    logic mask_bit;
    logic we;
    logic wdata;
    logic [NW-1:0] waddr;
    logic re;
    logic [NW-1:0] raddr;

    assign val_ext = XW'(i_in_item.value);
    assign res_ext = XW'(r_res);
    assign mask_bit = r_value[r_lvl];

    always_comb begin
        we = 1'b0;
        wdata = 1'b1;
        waddr = r_clr_addr;
        if (i_cmd.clr_en) begin
            we = 1'b1;
            wdata = 1'b0;
        end else if (i_cmd.ins_leaf) begin
            we = 1'b1;
            waddr = {1'b1, r_value};
        end else if (i_cmd.climb) begin
            we = 1'b1;
            waddr = {1'b0, r_node[NW-1:1]};
        end
    end

    always_comb begin
        re = i_cmd.rd_leaf | i_cmd.rd_sib | i_cmd.rd_pref;
        raddr = {1'b1, r_value};
        if (i_cmd.rd_sib) begin
            raddr = {r_node[NW-1:1], ~r_node[0]};
        end else if (i_cmd.rd_pref) begin
            raddr = {r_node[NW-2:0], mask_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= val_ext[VALUE_BITS-1:0];
            r_node <= NW'(1);
            r_lvl <= LW'(VALUE_BITS - 1);
            r_res <= '0;
            r_was_new <= 1'b0;
        end else if (i_cmd.ins_leaf) begin
            r_node <= {1'b1, r_value};
            r_was_new <= 1'b1;
        end else if (i_cmd.climb) begin
            r_node <= {1'b0, r_node[NW-1:1]};
        end else if (i_cmd.q_step) begin
            if (r_rdata) begin
                r_res[r_lvl] <= 1'b1;
                r_node <= {r_node[NW-2:0], ~mask_bit};
            end else begin
                r_node <= {r_node[NW-2:0], mask_bit};
            end
            r_lvl <= r_lvl - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.answer <= res_ext[FIELD_W-1:0];
            r_out.was_new <= r_was_new;
        end
    end

    assign o_stat.clr_done = (r_clr_addr == {NW{1'b1}});
    assign o_stat.rd_full = r_rdata;
    assign o_stat.node_at_top = (r_node[NW-1:1] == (NW-1)'(1));
    assign o_stat.lvl_zero = (r_lvl == '0);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;

endmodule

FILE: src/xmot_checker.sv
// Port checker for the occupancy tree block and its bind to the top level.
`include "xor_mex_occupancy_tree_top_assert.svh"

module xmot_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input xmot_pkg::t_out_item o_out_item
);
    import xmot_pkg::*;

    `XMOT_ASSERT_NEXT(a_one_item_at_a_time, i_in_valid && !o_in_stall, o_in_stall)
    `XMOT_ASSERT_NOW(a_insert_or_query_fields, o_out_valid,
        !o_out_item.was_new || (o_out_item.answer == '0))
    `XMOT_ASSERT_NEXT(a_out_valid_held, o_out_valid && i_out_stall, o_out_valid)
    `XMOT_ASSERT_NOW(a_out_drop_after_beat, $fell(o_out_valid), $past(!i_out_stall))

endmodule

bind xor_mex_occupancy_tree_top xmot_checker u_xmot_checker (.*);

FILE: test/tb_xor_mex_occupancy_tree_top.sv
// Self-checking testbench for the XOR mex occupancy tree: inserts, queries and a block fill.
`timescale 1ns / 100ps

module tb_xor_mex_occupancy_tree_top;
    import xmot_pkg::*;

    localparam int VB = VALUE_BITS_DEFAULT;
    localparam int NODES = 1 << (VB + 1);
    localparam logic [FIELD_W-1:0] VAL_MASK = FIELD_W'((1 << VB) - 1);
    localparam int BLOCK = 256;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 2 * VB + 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;

    bit          occupied [NODES];
    t_out_item   pending_results [$];
    bit          idle_on;
    int          fail_count;
    int          cycle_count;

    xor_mex_occupancy_tree_top #(
        .VALUE_BITS(VB)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit add_member(logic [FIELD_W-1:0] v);
        int node;
        int parent;
        node = (1 << VB) | int'(v & VAL_MASK);
        if (occupied[node]) begin
            return 1'b0;
        end
        occupied[node] = 1'b1;
        while (node > 1) begin
            parent = node >> 1;
            if (!(occupied[parent << 1] && occupied[(parent << 1) | 1])) begin
                break;
            end
            occupied[parent] = 1'b1;
            node = parent;
        end
        return 1'b1;
    endfunction

    function automatic logic [FIELD_W-1:0] mex_under_mask(logic [FIELD_W-1:0] mask);
        int node;
        int pref;
        int bit_t;
        logic [FIELD_W-1:0] res;
        node = 1;
        res = '0;
        for (int i = VB - 1; i >= 0; i--) begin
            bit_t = int'(mask[i]);
            pref = (node << 1) | bit_t;
            if (occupied[pref]) begin
                res[i] = 1'b1;
                node = (node << 1) | (bit_t ^ 1);
            end else begin
                node = pref;
            end
        end
        return res;
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item r;
        r = '0;
        if (it.func == FUNC_INSERT) begin
            r.was_new = add_member(it.value);
        end else begin
            r.answer = mex_under_mask(it.value);
        end
        return r;
    endfunction

    task automatic send_beat(input logic f, input logic [FIELD_W-1:0] v);
        t_in_item it;
        int gap;
        it.func = f;
        it.value = v;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pending_results.push_back(predict_result(it));
    endtask

    initial begin : out_stall_driver
        int stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (!idle_on) begin
                stall_left = 0;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result beat: answer=%h was_new=%b",
                             o_out_item.answer, o_out_item.was_new);
                end
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.answer !== want.answer || o_out_item.was_new !== want.was_new) begin
                    if (fail_count < 10) begin
                        $display("mismatch: expected answer=%h was_new=%b, got answer=%h was_new=%b",
                                 want.answer, want.was_new, o_out_item.answer,
                                 o_out_item.was_new);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[xor_mex_occupancy_tree_top] ERROR");
        $finish;
    end

    task automatic test_empty_set();
        send_beat(FUNC_QUERY, 12'h000);
        send_beat(FUNC_QUERY, 12'hFFF);
    endtask

    task automatic test_insert_and_duplicates();
        send_beat(FUNC_INSERT, 12'h000);
        send_beat(FUNC_INSERT, 12'h000);
        send_beat(FUNC_INSERT, 12'hFFF);
        send_beat(FUNC_INSERT, 12'hFFF);
        send_beat(FUNC_INSERT, 12'h001);
        send_beat(FUNC_INSERT, 12'h002);
        send_beat(FUNC_INSERT, 12'h003);
        send_beat(FUNC_INSERT, 12'h002);
    endtask

    task automatic test_directed_queries();
        send_beat(FUNC_QUERY, 12'h000);
        send_beat(FUNC_QUERY, 12'hFFF);
        send_beat(FUNC_QUERY, 12'h003);
        send_beat(FUNC_QUERY, 12'h800);
        send_beat(FUNC_INSERT, 12'hAAA);
        send_beat(FUNC_INSERT, 12'h555);
        send_beat(FUNC_QUERY, 12'hAAA);
        send_beat(FUNC_QUERY, 12'h555);
        send_beat(FUNC_QUERY, 12'hFFC);
    endtask

    task automatic test_random_mix();
        logic [FIELD_W-1:0] base;
        int span;
        int kind;
        for (int chunk = 0; chunk < 7; chunk++) begin
            idle_on = (chunk != 3);
            span = 1 << $urandom_range(2, 6);
            base = FIELD_W'($urandom_range(0, (1 << VB) - 1) & ~(span - 1)) & VAL_MASK;
            for (int n = 0; n < 60; n++) begin
                kind = $urandom_range(0, 9);
                if (kind < 4) begin
                    send_beat(FUNC_INSERT, base | FIELD_W'($urandom_range(0, span - 1)));
                end else if (kind == 4) begin
                    send_beat(FUNC_INSERT, FIELD_W'($urandom_range(0, (1 << VB) - 1)));
                end else if (kind < 7) begin
                    send_beat(FUNC_QUERY, base ^ FIELD_W'($urandom_range(0, 2 * span - 1)));
                end else begin
                    send_beat(FUNC_QUERY, FIELD_W'($urandom_range(0, (1 << VB) - 1)));
                end
            end
        end
    endtask

    task automatic test_fill_block();
        logic [FIELD_W-1:0] base;
        int stride;
        int start;
        idle_on = 1'b0;
        base = FIELD_W'($urandom_range(0, (1 << VB) - 1)) & ~FIELD_W'(BLOCK - 1);
        stride = 2 * $urandom_range(0, BLOCK / 2 - 1) + 1;
        start = $urandom_range(0, BLOCK - 1);
        for (int i = 0; i < BLOCK; i++) begin
            send_beat(FUNC_INSERT, base | FIELD_W'((start + i * stride) & (BLOCK - 1)));
            if (i == BLOCK / 2 - 1) begin
                send_beat(FUNC_QUERY, base ^ FIELD_W'($urandom_range(0, BLOCK - 1)));
            end
        end
        send_beat(FUNC_INSERT, base | FIELD_W'(start & (BLOCK - 1)));
        send_beat(FUNC_QUERY, base);
        send_beat(FUNC_QUERY, base ^ FIELD_W'(BLOCK - 1));
        send_beat(FUNC_QUERY, FIELD_W'($urandom_range(0, (1 << VB) - 1)));
    endtask

    initial begin : main_sequence
        fail_count = 0;
        idle_on = 1'b1;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_set();
        test_insert_and_duplicates();
        test_directed_queries();
        test_random_mix();
        test_fill_block();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[xor_mex_occupancy_tree_top] OK");
        end else begin
            $display("[xor_mex_occupancy_tree_top] ERROR");
        end
        $finish;
    end

endmodule
